### rtl/tspt_pkg.sv
// Package for the speed profile tick block: state codes, register map,
// fixed-point constants and sequencer states. No dependencies.
package tspt_pkg;

   // Motion status codes
   localparam logic [1:0] STATUS_IDLE  = 2'd0;
   localparam logic [1:0] STATUS_RUN   = 2'd1;
   localparam logic [1:0] STATUS_EMERG = 2'd2;

   // Register indexes, taken from csr_paddr[3:2]
   localparam logic [1:0] CSR_CIVIL_LIMIT = 2'd0;
   localparam logic [1:0] CSR_OPER_MAX    = 2'd1;
   localparam logic [1:0] CSR_ACCEL       = 2'd2;
   localparam logic [1:0] CSR_DECEL       = 2'd3;

   localparam logic [15:0] ACCEL_RESET = 16'd6400;
   localparam logic [15:0] DECEL_RESET = 16'd5120;

   // Q7.16 loop length, stop margin, and the position scale divisor
   localparam logic [23:0] LOOP_Q16    = 24'd6553600;
   localparam logic [22:0] STOP_MARGIN = 23'd6554;
   localparam logic [11:0] POS_DIVISOR = 12'd1600;

   // Last step of the serial multiply (16 multiplier bits) and divide (32 bits)
   localparam logic [4:0] MUL_LAST = 5'd15;
   localparam logic [4:0] DIV_LAST = 5'd31;

   typedef enum logic [9:0] {
      SEQ_IDLE  = 10'b00_0000_0001,
      SEQ_MDIST = 10'b00_0000_0010,
      SEQ_MVV   = 10'b00_0000_0100,
      SEQ_SEL   = 10'b00_0000_1000,
      SEQ_MRATE = 10'b00_0001_0000,
      SEQ_UPD   = 10'b00_0010_0000,
      SEQ_MPOS  = 10'b00_0100_0000,
      SEQ_DIV   = 10'b00_1000_0000,
      SEQ_POS   = 10'b01_0000_0000,
      SEQ_FIN   = 10'b10_0000_0000
   } seq_state_type;

endpackage

### rtl/train_speed_profile_tick_top.sv
// Speed profile tick block: one tick of a trapezoidal velocity profile with
// a braking curve on a closed loop. Depends on tspt_pkg.
//
// Usage:
//  - Request channel (req_*): one request per tick carries the time step,
//    the movement-authority position, an interlock fault and an emergency
//    request. A request is taken when req_valid is high and req_stall low.
//  - Response channel (rsp_*): one response per request with the new
//    position, velocity and motion status, held in an output register until
//    taken (rsp_valid high, rsp_stall low).
//  - Register port (csr_*): four 16-bit registers at byte addresses 0, 4, 8
//    and 12: civil speed limit, operator max speed, accel rate, decel rate.
//    pready is always high; write only while the block is idle.
//  - Sequence: a running tick passes through the serial multiply and divide
//    states before its response; a frozen tick (fault or emergency) or a
//    stop tick goes straight to the response. The next request is taken in
//    the cycle after the response is loaded. The work is done by one shared
//    bit-serial multiplier (four products, 16 multiplier bits each) and a
//    bit-serial divide by 1600 (32 quotient bits).
//  - When the receiver stalls, the finished response waits in the sequencer
//    until the output register frees; no new request is taken meanwhile.
//  - Reset (synchronous, active high) clears position, velocity and status,
//    and loads the register defaults.
module train_speed_profile_tick_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_tick_seconds,
   input  logic [22:0] req_authority_position,
   input  logic        req_interlock_fault,
   input  logic        req_emergency_brake,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [22:0] rsp_position_now,
   output logic [15:0] rsp_velocity_now,
   output logic [1:0]  rsp_motion_status,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers
   logic [15:0] civil_ff, oper_ff, accel_ff, decel_ff;
   logic        csr_wr;

   // Architectural state
   logic [22:0] pos_ff, pos_in;
   logic [15:0] vel_ff, vel_in;
   logic [1:0]  status_ff, status_in;

   // Sequencer and serial datapath
   tspt_pkg::seq_state_type state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [38:0] prod_ff, prod_in;
   logic [22:0] mcand_ff, mcand_in;
   logic [38:0] lhs_ff, lhs_in;
   logic        braking_ff, braking_in;
   logic [10:0] rem_ff, rem_in;
   logic [15:0] dt_ff, dt_in;

   // Output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [22:0] rsp_pos_ff, rsp_pos_in;
   logic [15:0] rsp_vel_ff, rsp_vel_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   // Combinational helpers
   logic [23:0] sum_mul;
   logic [38:0] prod_mul;
   logic [11:0] div_t;
   logic        div_ge;
   logic [11:0] div_sub;
   logic [38:0] prod_div;
   logic [23:0] dist_raw, dist_wrap;
   logic [22:0] auth_dist;
   logic        stop_now;
   logic [15:0] ceil_v;
   logic        brk_now;
   logic [19:0] step;
   logic [20:0] acc_sum;
   logic [15:0] over_diff;
   logic [15:0] vnew;
   logic [23:0] pos_sum, pos_wrap;

   //------------------------------------------------------------------
   // Register port
   //------------------------------------------------------------------
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         civil_ff <= '0;
         oper_ff  <= '0;
         accel_ff <= tspt_pkg::ACCEL_RESET;
         decel_ff <= tspt_pkg::DECEL_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            tspt_pkg::CSR_CIVIL_LIMIT: civil_ff <= csr_pwdata[15:0];
            tspt_pkg::CSR_OPER_MAX:    oper_ff  <= csr_pwdata[15:0];
            tspt_pkg::CSR_ACCEL:       accel_ff <= csr_pwdata[15:0];
            tspt_pkg::CSR_DECEL:       decel_ff <= csr_pwdata[15:0];
            default:                   civil_ff <= civil_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         tspt_pkg::CSR_CIVIL_LIMIT: csr_prdata = {16'd0, civil_ff};
         tspt_pkg::CSR_OPER_MAX:    csr_prdata = {16'd0, oper_ff};
         tspt_pkg::CSR_ACCEL:       csr_prdata = {16'd0, accel_ff};
         tspt_pkg::CSR_DECEL:       csr_prdata = {16'd0, decel_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   //------------------------------------------------------------------
   // Serial arithmetic
   //------------------------------------------------------------------
   // Shift-add multiply: the multiplier sits in the low 16 bits of prod_ff
   // and shifts out LSB first while the partial sum enters from the top.
   assign sum_mul  = {1'b0, prod_ff[38:16]} + (prod_ff[0] ? {1'b0, mcand_ff} : 24'd0);
   assign prod_mul = {sum_mul, prod_ff[15:1]};

   // Restoring divide by 1600, one quotient bit per cycle, MSB of the
   // dividend first; the quotient shifts in at the bottom.
   assign div_t    = {rem_ff, prod_ff[31]};
   assign div_ge   = (div_t >= tspt_pkg::POS_DIVISOR);
   assign div_sub  = div_t - tspt_pkg::POS_DIVISOR;
   assign prod_div = {7'd0, prod_ff[30:0], div_ge};

   // Distance to authority, wrapped once around the loop if negative
   assign dist_raw  = {1'b0, req_authority_position} - {1'b0, pos_ff};
   assign dist_wrap = dist_raw + tspt_pkg::LOOP_Q16;
   assign auth_dist = dist_raw[23] ? dist_wrap[22:0] : dist_raw[22:0];
   assign stop_now  = (auth_dist <= tspt_pkg::STOP_MARGIN) ||
                      (req_authority_position == 23'd0);

   assign ceil_v = (civil_ff < oper_ff) ? civil_ff : oper_ff;

   // Stopping test: 2 * dist * decel <= (v * v) << 8, both in Q.24
   assign brk_now = ({lhs_ff, 1'b0} <= {prod_ff[31:0], 8'd0});

   // Velocity update from rate * dt, truncated to Q8.8
   assign step      = prod_ff[31:12];
   assign acc_sum   = {5'd0, vel_ff} + {1'b0, step};
   assign over_diff = vel_ff - ceil_v;

   always_comb begin
      if (braking_ff) begin
         vnew = (step >= {4'd0, vel_ff}) ? 16'd0 : vel_ff - step[15:0];
      end else if (vel_ff < ceil_v) begin
         vnew = (acc_sum > {5'd0, ceil_v}) ? ceil_v : acc_sum[15:0];
      end else if (vel_ff > ceil_v) begin
         vnew = (step > {4'd0, over_diff}) ? ceil_v : vel_ff - step[15:0];
      end else begin
         vnew = vel_ff;
      end
   end

   // Position advance by the quotient, wrapping at the loop length
   assign pos_sum  = {1'b0, pos_ff} + {2'd0, prod_ff[21:0]};
   assign pos_wrap = (pos_sum >= tspt_pkg::LOOP_Q16) ? pos_sum - tspt_pkg::LOOP_Q16 : pos_sum;

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   assign req_stall = (state_ff != tspt_pkg::SEQ_IDLE);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      mcand_in      = mcand_ff;
      lhs_in        = lhs_ff;
      braking_in    = braking_ff;
      rem_in        = rem_ff;
      dt_in         = dt_ff;
      pos_in        = pos_ff;
      vel_in        = vel_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         tspt_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               dt_in = req_tick_seconds;
               if ((status_ff == tspt_pkg::STATUS_EMERG) || req_emergency_brake) begin
                  // sticky emergency: zero velocity, freeze position
                  vel_in    = '0;
                  status_in = tspt_pkg::STATUS_EMERG;
                  state_in  = tspt_pkg::SEQ_FIN;
               end else if (req_interlock_fault) begin
                  vel_in   = '0;
                  state_in = tspt_pkg::SEQ_FIN;
               end else if (stop_now) begin
                  vel_in    = '0;
                  status_in = tspt_pkg::STATUS_IDLE;
                  state_in  = tspt_pkg::SEQ_FIN;
               end else begin
                  status_in = tspt_pkg::STATUS_RUN;
                  mcand_in  = auth_dist;
                  prod_in   = {23'd0, decel_ff};
                  cnt_in    = '0;
                  state_in  = tspt_pkg::SEQ_MDIST;
               end
            end
         end
         tspt_pkg::SEQ_MDIST: begin
            prod_in = prod_mul;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == tspt_pkg::MUL_LAST) begin
               lhs_in   = prod_mul;
               mcand_in = {7'd0, vel_ff};
               prod_in  = {23'd0, vel_ff};
               cnt_in   = '0;
               state_in = tspt_pkg::SEQ_MVV;
            end
         end
         tspt_pkg::SEQ_MVV: begin
            prod_in = prod_mul;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == tspt_pkg::MUL_LAST) begin
               cnt_in   = '0;
               state_in = tspt_pkg::SEQ_SEL;
            end
         end
         tspt_pkg::SEQ_SEL: begin
            braking_in = brk_now;
            mcand_in   = {7'd0, (brk_now || (vel_ff > ceil_v)) ? decel_ff : accel_ff};
            prod_in    = {23'd0, dt_ff};
            state_in   = tspt_pkg::SEQ_MRATE;
         end
         tspt_pkg::SEQ_MRATE: begin
            prod_in = prod_mul;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == tspt_pkg::MUL_LAST) begin
               cnt_in   = '0;
               state_in = tspt_pkg::SEQ_UPD;
            end
         end
         tspt_pkg::SEQ_UPD: begin
            vel_in   = vnew;
            mcand_in = {7'd0, vnew};
            prod_in  = {23'd0, dt_ff};
            state_in = tspt_pkg::SEQ_MPOS;
         end
         tspt_pkg::SEQ_MPOS: begin
            prod_in = prod_mul;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == tspt_pkg::MUL_LAST) begin
               rem_in   = '0;
               cnt_in   = '0;
               state_in = tspt_pkg::SEQ_DIV;
            end
         end
         tspt_pkg::SEQ_DIV: begin
            prod_in = prod_div;
            rem_in  = div_ge ? div_sub[10:0] : div_t[10:0];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == tspt_pkg::DIV_LAST) begin
               cnt_in   = '0;
               state_in = tspt_pkg::SEQ_POS;
            end
         end
         tspt_pkg::SEQ_POS: begin
            pos_in   = pos_wrap[22:0];
            state_in = tspt_pkg::SEQ_FIN;
         end
         tspt_pkg::SEQ_FIN: begin
            // hold until the output register is free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in  = 1'b1;
               rsp_pos_in    = pos_ff;
               rsp_vel_in    = vel_ff;
               rsp_status_in = status_ff;
               state_in      = tspt_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = tspt_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspt_pkg::SEQ_IDLE;
         cnt_ff       <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         status_ff    <= tspt_pkg::STATUS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff       <= prod_in;
      mcand_ff      <= mcand_in;
      lhs_ff        <= lhs_in;
      braking_ff    <= braking_in;
      rem_ff        <= rem_in;
      dt_ff         <= dt_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_now  = rsp_pos_ff;
   assign rsp_velocity_now  = rsp_vel_ff;
   assign rsp_motion_status = rsp_status_ff;

   //------------------------------------------------------------------
   // Assertions
   //------------------------------------------------------------------
   // Emergency state is sticky until reset
   a_emerg_sticky: assert property (@(posedge clock) disable iff (reset)
      (status_ff == tspt_pkg::STATUS_EMERG) |=> (status_ff == tspt_pkg::STATUS_EMERG))
      else $error("emergency status left without reset");

   // Position always stays inside the loop
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, pos_ff} < tspt_pkg::LOOP_Q16))
      else $error("position outside loop");

   // Only a running vehicle may have nonzero velocity
   a_vel_status: assert property (@(posedge clock) disable iff (reset)
      (status_ff != tspt_pkg::STATUS_RUN) |-> (vel_ff == 16'd0))
      else $error("nonzero velocity while not running");

   // A request taken in idle always starts work
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted without leaving idle");

endmodule
